// ===== rtl/a64enc_pkg.sv =====
// shared types, constants and helpers for the aarch64 subset encoder
// no dependencies; used by the channel interfaces and the top level

package a64enc_pkg;

  localparam int unsigned OpWidth   = 4;
  localparam int unsigned CondWidth = 4;
  localparam int unsigned OperWidth = 32;
  localparam int unsigned WordWidth = 32;
  localparam int unsigned StWidth   = 2;

  typedef enum logic [OpWidth-1:0] {
    OP_ADD     = 4'd0,
    OP_SUB     = 4'd1,
    OP_MUL     = 4'd2,
    OP_SMULH   = 4'd3,
    OP_UMULH   = 4'd4,
    OP_SDIV    = 4'd5,
    OP_UDIV    = 4'd6,
    OP_CMP     = 4'd7,
    OP_BR      = 4'd8,
    OP_BLR     = 4'd9,
    OP_LDUR    = 4'd10,
    OP_STUR    = 4'd11,
    OP_LDR     = 4'd12,
    OP_B       = 4'd13,
    OP_BCOND   = 4'd14,
    OP_UNKNOWN = 4'd15
  } op_e;

  typedef enum logic [StWidth-1:0] {
    ST_OK         = 2'd0,
    ST_UNKNOWN    = 2'd1,
    ST_MISALIGNED = 2'd2,
    ST_RANGE      = 2'd3
  } status_e;

  // base words of the three-register forms, indexed by opcode 0..7
  localparam logic [WordWidth-1:0] R3_BASE [8] = '{
    32'h8B20_6000, 32'hCB20_6000, 32'h9B00_7C00, 32'h9B40_7C00,
    32'h9BC0_7C00, 32'h9AC0_0C00, 32'h9AC0_0800, 32'hEB20_6000
  };

  localparam logic [WordWidth-1:0] BASE_BR    = 32'hD61F_0000;
  localparam logic [WordWidth-1:0] BASE_BLR   = 32'hD63F_0000;
  localparam logic [WordWidth-1:0] BASE_LDUR  = 32'hF840_0000;
  localparam logic [WordWidth-1:0] BASE_STUR  = 32'hF800_0000;
  localparam logic [WordWidth-1:0] BASE_LDR   = 32'h5800_0000;
  localparam logic [WordWidth-1:0] BASE_B     = 32'h1400_0000;
  localparam logic [WordWidth-1:0] BASE_BCOND = 32'h5400_0000;

  localparam logic [4:0] REG_ZR = 5'd31;

  function automatic logic cond_valid(input logic [CondWidth-1:0] cond);
    return cond inside {[4'd0:4'd3], [4'd8:4'd13]};
  endfunction

  function automatic logic [WordWidth-1:0] swap_bytes(input logic [WordWidth-1:0] w);
    return {w[7:0], w[15:8], w[23:16], w[31:24]};
  endfunction

endpackage

// ===== rtl/a64enc_req_if.sv =====
// request channel: valid/ready plus one instruction request
// depends on a64enc_pkg

interface a64enc_req_if import a64enc_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic [OpWidth-1:0]          opcode;
  logic [CondWidth-1:0]        branch_condition;
  logic signed [OperWidth-1:0] operand_first;
  logic signed [OperWidth-1:0] operand_second;
  logic signed [OperWidth-1:0] operand_third;

  modport source (
    output valid, opcode, branch_condition, operand_first, operand_second, operand_third,
    input  ready
  );
  modport sink (
    input  valid, opcode, branch_condition, operand_first, operand_second, operand_third,
    output ready
  );
endinterface

// ===== rtl/a64enc_rsp_if.sv =====
// response channel: valid/ready plus the encoded word and status
// depends on a64enc_pkg

interface a64enc_rsp_if import a64enc_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [WordWidth-1:0] instruction_word;
  logic [StWidth-1:0]   status;

  modport source (output valid, instruction_word, status, input ready);
  modport sink   (input valid, instruction_word, status, output ready);
endinterface

// ===== rtl/arm64_subset_instruction_encoder.sv =====
// aarch64 subset encoder: a request passes the input register and then the result register
// before its response is valid
// throughput one transaction per cycle while the response side keeps ready high; the input register
// and result register form a two-stage pipeline, each stage refills in the cycle it empties
// rst_ni (async, active low) clears both stage valid flags; payload is not reset
// depends on a64enc_pkg, a64enc_req_if and a64enc_rsp_if

module arm64_subset_instruction_encoder import a64enc_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  a64enc_req_if.sink   req_i,
  a64enc_rsp_if.source rsp_o
);

  // input register stage
  logic                        in_vld_q;
  op_e                         op_q;
  logic [CondWidth-1:0]        cond_q;
  logic signed [OperWidth-1:0] opa_q, opb_q, opc_q;

  // result register stage
  logic                 out_vld_q;
  logic [WordWidth-1:0] word_q, word_d;
  status_e              st_q, st_d;

  logic out_free;   // result register can take a new value this cycle
  logic in_free;    // input register can take a new request this cycle

  assign out_free    = !out_vld_q || rsp_o.ready;
  assign in_free     = !in_vld_q || out_free;
  assign req_i.ready = in_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_free) begin
      in_vld_q <= req_i.valid;
    end
  end

  // payload capture only on a request transaction
  always_ff @(posedge clk_i) begin
    if (in_free && req_i.valid) begin
      op_q   <= op_e'(req_i.opcode);
      cond_q <= req_i.branch_condition;
      opa_q  <= req_i.operand_first;
      opb_q  <= req_i.operand_second;
      opc_q  <= req_i.operand_third;
    end
  end

  // register fields: only the low five bits of each operand
  logic [4:0] ra, rb, rc;
  assign ra = opa_q[4:0];
  assign rb = opb_q[4:0];
  assign rc = opc_q[4:0];

  // offset checks: aligned means low two bits clear; the word offset fits in
  // n bits when all bits above bit (n+1) of the byte offset match bit (n+1)
  logic a_misal, b_misal;
  logic a_fit19, a_fit26, b_fit19, imm_fit9;
  assign a_misal  = opa_q[1:0] != 2'b00;
  assign b_misal  = opb_q[1:0] != 2'b00;
  assign a_fit19  = (opa_q[31:20] == '0) || (opa_q[31:20] == '1);
  assign a_fit26  = (opa_q[31:27] == '0) || (opa_q[31:27] == '1);
  assign b_fit19  = (opb_q[31:20] == '0) || (opb_q[31:20] == '1);
  assign imm_fit9 = (opc_q[31:8] == '0) || (opc_q[31:8] == '1);

  logic [WordWidth-1:0] enc;

  always_comb begin
    enc  = '0;
    st_d = ST_OK;
    case (op_q)
      OP_ADD, OP_SUB, OP_MUL, OP_SMULH, OP_UMULH, OP_SDIV, OP_UDIV: begin
        enc = R3_BASE[op_q[2:0]] | {11'd0, rc, 6'd0, rb, ra};
      end
      OP_CMP: begin
        // subs with the zero register as destination
        enc = R3_BASE[op_q[2:0]] | {11'd0, rb, 6'd0, ra, REG_ZR};
      end
      OP_BR: begin
        enc = BASE_BR | {22'd0, ra, 5'd0};
      end
      OP_BLR: begin
        enc = BASE_BLR | {22'd0, ra, 5'd0};
      end
      OP_LDUR, OP_STUR: begin
        if (!imm_fit9) begin
          st_d = ST_RANGE;
        end else begin
          enc = ((op_q == OP_LDUR) ? BASE_LDUR : BASE_STUR) |
                {11'd0, opc_q[8:0], 2'd0, rb, ra};
        end
      end
      OP_LDR: begin
        if (b_misal) begin
          st_d = ST_MISALIGNED;
        end else if (!b_fit19) begin
          st_d = ST_RANGE;
        end else begin
          enc = BASE_LDR | {8'd0, opb_q[20:2], ra};
        end
      end
      OP_B: begin
        if (a_misal) begin
          st_d = ST_MISALIGNED;
        end else if (!a_fit26) begin
          st_d = ST_RANGE;
        end else begin
          enc = BASE_B | {6'd0, opa_q[27:2]};
        end
      end
      OP_BCOND: begin
        // bad condition code wins over the offset checks
        if (!cond_valid(cond_q)) begin
          st_d = ST_UNKNOWN;
        end else if (a_misal) begin
          st_d = ST_MISALIGNED;
        end else if (!a_fit19) begin
          st_d = ST_RANGE;
        end else begin
          enc = BASE_BCOND | {8'd0, opa_q[20:2], 1'b0, cond_q};
        end
      end
      default: begin
        st_d = ST_UNKNOWN;
      end
    endcase
  end

  // errored requests return an all-zero word
  assign word_d = (st_d == ST_OK) ? swap_bytes(enc) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_free) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && in_vld_q) begin
      word_q <= word_d;
      st_q   <= st_d;
    end
  end

  assign rsp_o.valid            = out_vld_q;
  assign rsp_o.instruction_word = word_q;
  assign rsp_o.status           = st_q;

  // a failing response never carries an encoded word
  a_err_zero_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && st_q != ST_OK) |-> (word_q == '0))
    else $error("nonzero word on an error response");

  // a response only appears after the input stage held a request
  a_rsp_from_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(in_vld_q))
    else $error("response valid without a staged request");

  // a full input stage that cannot drain must refuse new requests
  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && !out_free) |-> !req_i.ready)
    else $error("request accepted over a stalled stage");

  // unknown opcode moved into the result register reports unknown
  a_unknown_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && out_free && op_q == OP_UNKNOWN) |=> (st_q == ST_UNKNOWN))
    else $error("unknown opcode not flagged");

endmodule

// ===== test/tb_arm64_subset_instruction_encoder.sv =====
// testbench for arm64_subset_instruction_encoder: random and directed instruction requests,
// every response checked in order against a predictor of the encoding and status
// depends on a64enc_pkg, a64enc_req_if, a64enc_rsp_if and the encoder rtl

module tb_arm64_subset_instruction_encoder import a64enc_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NumRandom = 1450;

  // base words of every instruction form, taken from the architecture
  localparam logic [31:0] ADD_WORD   = 32'h8B20_6000;
  localparam logic [31:0] SUB_WORD   = 32'hCB20_6000;
  localparam logic [31:0] MUL_WORD   = 32'h9B00_7C00;
  localparam logic [31:0] SMULH_WORD = 32'h9B40_7C00;
  localparam logic [31:0] UMULH_WORD = 32'h9BC0_7C00;
  localparam logic [31:0] SDIV_WORD  = 32'h9AC0_0C00;
  localparam logic [31:0] UDIV_WORD  = 32'h9AC0_0800;
  localparam logic [31:0] SUBS_WORD  = 32'hEB20_6000;
  localparam logic [31:0] BR_WORD    = 32'hD61F_0000;
  localparam logic [31:0] BLR_WORD   = 32'hD63F_0000;
  localparam logic [31:0] LDUR_WORD  = 32'hF840_0000;
  localparam logic [31:0] STUR_WORD  = 32'hF800_0000;
  localparam logic [31:0] LDR_WORD   = 32'h5800_0000;
  localparam logic [31:0] B_WORD     = 32'h1400_0000;
  localparam logic [31:0] BCOND_WORD = 32'h5400_0000;

  localparam logic [4:0] ZERO_REG = 5'd31;

  // condition codes used by the directed part
  localparam logic [3:0] COND_EQ = 4'd0;
  localparam logic [3:0] COND_LO = 4'd3;
  localparam logic [3:0] COND_MI = 4'd4;
  localparam logic [3:0] COND_VC = 4'd7;
  localparam logic [3:0] COND_HI = 4'd8;
  localparam logic [3:0] COND_LE = 4'd13;
  localparam logic [3:0] COND_AL = 4'd14;
  localparam logic [3:0] COND_NV = 4'd15;

  typedef struct packed {
    logic [OpWidth-1:0]          opcode;
    logic [CondWidth-1:0]        cond;
    logic signed [OperWidth-1:0] first;
    logic signed [OperWidth-1:0] second;
    logic signed [OperWidth-1:0] third;
  } instr_req_t;

  typedef struct {
    logic [WordWidth-1:0] word;
    status_e              status;
  } encoding_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  a64enc_req_if req_if ();
  a64enc_rsp_if rsp_if ();

  arm64_subset_instruction_encoder u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  // testbench-side drive registers, known from time zero
  logic       req_valid = 1'b0;
  instr_req_t req_item  = '0;
  logic       rsp_ready = 1'b0;

  assign req_if.valid            = req_valid;
  assign req_if.opcode           = req_item.opcode;
  assign req_if.branch_condition = req_item.cond;
  assign req_if.operand_first    = req_item.first;
  assign req_if.operand_second   = req_item.second;
  assign req_if.operand_third    = req_item.third;
  assign rsp_if.ready            = rsp_ready;

  instr_req_t pending_requests[$];
  encoding_t  expected_encodings[$];
  int         mismatch_count = 0;

  // idle counters and burst modes of both sides
  int   req_gap_left  = 0;
  int   rsp_stall_left = 0;
  int   rsp_idle = 0;
  logic req_burst = 1'b0;
  logic rsp_burst = 1'b0;

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // alignment then range check of a byte offset; word_off gets offset / 4
  function automatic status_e check_offset(input logic signed [31:0] off, input int bits,
                                           output int word_off);
    int lim;
    lim      = 1 << (bits - 1);
    word_off = 0;
    if (off[1:0] != 2'b00) return ST_MISALIGNED;
    word_off = off >>> 2;
    if (word_off < -lim || word_off >= lim) return ST_RANGE;
    return ST_OK;
  endfunction

  function automatic encoding_t encode_request(input instr_req_t r);
    encoding_t   res;
    logic [31:0] enc;
    logic [31:0] three_reg;
    status_e     st;
    int          word_off;
    enc       = '0;
    st        = ST_OK;
    // rm at 20:16, rn at 9:5, rd at 4:0
    three_reg = {11'b0, r.third[4:0], 6'b0, r.second[4:0], r.first[4:0]};
    case (op_e'(r.opcode))
      OP_ADD:   enc = ADD_WORD | three_reg;
      OP_SUB:   enc = SUB_WORD | three_reg;
      OP_MUL:   enc = MUL_WORD | three_reg;
      OP_SMULH: enc = SMULH_WORD | three_reg;
      OP_UMULH: enc = UMULH_WORD | three_reg;
      OP_SDIV:  enc = SDIV_WORD | three_reg;
      OP_UDIV:  enc = UDIV_WORD | three_reg;
      // cmp is subs to the zero register, rn from the first operand
      OP_CMP:   enc = SUBS_WORD | {11'b0, r.second[4:0], 6'b0, r.first[4:0], ZERO_REG};
      OP_BR:    enc = BR_WORD | {22'b0, r.first[4:0], 5'b0};
      OP_BLR:   enc = BLR_WORD | {22'b0, r.first[4:0], 5'b0};
      OP_LDUR, OP_STUR: begin
        if (r.third < -256 || r.third > 255) begin
          st = ST_RANGE;
        end else begin
          enc = (op_e'(r.opcode) == OP_LDUR) ? LDUR_WORD : STUR_WORD;
          enc = enc | {11'b0, r.third[8:0], 2'b0, r.second[4:0], r.first[4:0]};
        end
      end
      OP_LDR: begin
        st = check_offset(r.second, 19, word_off);
        enc = LDR_WORD | {8'b0, word_off[18:0], r.first[4:0]};
      end
      OP_B: begin
        st = check_offset(r.first, 26, word_off);
        enc = B_WORD | {6'b0, word_off[25:0]};
      end
      OP_BCOND: begin
        // an invalid condition wins over any offset problem
        if (!(r.cond <= 4'd3 || (r.cond >= 4'd8 && r.cond <= 4'd13))) begin
          st = ST_UNKNOWN;
        end else begin
          st = check_offset(r.first, 19, word_off);
          enc = BCOND_WORD | {8'b0, word_off[18:0], 1'b0, r.cond};
        end
      end
      default: st = ST_UNKNOWN;
    endcase
    res.status = st;
    res.word   = (st == ST_OK) ? {enc[7:0], enc[15:8], enc[23:16], enc[31:24]} : '0;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  task automatic push_request(input op_e op, input logic [3:0] cond, input logic [31:0] a,
                              input logic [31:0] b, input logic [31:0] c);
    instr_req_t item;
    item.opcode = op;
    item.cond   = cond;
    item.first  = a;
    item.second = b;
    item.third  = c;
    pending_requests.insert(pending_requests.size(), item);
  endtask

  // mostly legal word offsets, some at the field edges, some misaligned, some wild
  function automatic logic [31:0] pick_offset(input int bits);
    int lim;
    int sel;
    int word_off;
    lim = 1 << (bits - 1);
    sel = $urandom_range(0, 9);
    if (sel < 5) begin
      word_off = int'($urandom_range(0, 2 * lim - 1)) - lim;
      return word_off * 4;
    end else if (sel < 7) begin
      word_off = ($urandom_range(0, 1) ? lim - 1 : -lim) + int'($urandom_range(0, 4)) - 2;
      return word_off * 4;
    end else if (sel < 8) begin
      return int'($urandom_range(0, 4096)) * 4 - 8192 + int'($urandom_range(1, 3));
    end
    return $urandom;
  endfunction

  function automatic int draw_idle(input logic burst);
    if (burst) return 0;
    return $urandom_range(0, 14);
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // ---------------------------------------------------------------------------
  // clock
  // ---------------------------------------------------------------------------

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // request driver: one transaction per handshake, random gap after each
  // ---------------------------------------------------------------------------

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid    <= 1'b0;
      req_gap_left <= 0;
    end else begin
      if (req_valid && req_if.ready) begin
        // accepted: the expectation goes in now, well ahead of the response
        expected_encodings.insert(expected_encodings.size(), encode_request(req_item));
        if ($urandom_range(0, 31) == 0) req_burst = ~req_burst;
        req_gap_left = draw_idle(req_burst);
        if (req_gap_left == 0 && pending_requests.size() != 0) begin
          req_item  <= pending_requests.pop_front();
          req_valid <= 1'b1;
        end else begin
          req_valid <= 1'b0;
          // this cycle already counts toward the gap
          if (req_gap_left != 0) req_gap_left = req_gap_left - 1;
        end
      end else if (!req_valid) begin
        if (req_gap_left != 0) begin
          req_gap_left = req_gap_left - 1;
        end else if (pending_requests.size() != 0) begin
          req_item  <= pending_requests.pop_front();
          req_valid <= 1'b1;
        end
      end
      // valid held with the payload unchanged while ready is low
    end
  end

  // ---------------------------------------------------------------------------
  // response monitor: compare in order, random stall after each transaction
  // ---------------------------------------------------------------------------

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_ready      <= 1'b0;
      rsp_stall_left <= 0;
    end else begin
      if (rsp_if.valid && rsp_ready) begin
        if (expected_encodings.size() == 0) begin
          report_mismatch($sformatf("response %h/%0d with nothing expected",
                                    rsp_if.instruction_word, rsp_if.status));
        end else begin
          encoding_t exp_enc;
          exp_enc = expected_encodings.pop_front();
          if (rsp_if.status !== exp_enc.status)
            report_mismatch($sformatf("status %0d, expected %0d",
                                      rsp_if.status, exp_enc.status));
          if (rsp_if.instruction_word !== exp_enc.word)
            report_mismatch($sformatf("instruction_word %h, expected %h",
                                      rsp_if.instruction_word, exp_enc.word));
        end
        if ($urandom_range(0, 31) == 0) rsp_burst = ~rsp_burst;
        rsp_idle        = draw_idle(rsp_burst);
        rsp_stall_left <= rsp_idle;
        rsp_ready      <= (rsp_idle == 0) ? 1'b1 : 1'b0;
      end else if (rsp_stall_left != 0) begin
        rsp_stall_left <= rsp_stall_left - 1;
        rsp_ready      <= (rsp_stall_left == 1);
      end else begin
        rsp_ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus and end of run
  // ---------------------------------------------------------------------------

  initial begin
    instr_req_t item;
    int         sel;

    // directed: register extremes, every opcode, every error path
    push_request(OP_ADD, COND_EQ, 32'd0, 32'd0, 32'd0);
    push_request(OP_ADD, COND_NV, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    for (int k = OP_SUB; k <= OP_BLR; k++)
      push_request(op_e'(k), 4'($urandom_range(0, 15)), $urandom, $urandom, $urandom);
    // unscaled immediate at both edges and just past them
    push_request(OP_LDUR, COND_EQ, $urandom, $urandom, -32'sd256);
    push_request(OP_STUR, COND_EQ, $urandom, $urandom, 32'sd255);
    push_request(OP_LDUR, COND_EQ, $urandom, $urandom, 32'sd256);
    push_request(OP_STUR, COND_EQ, $urandom, $urandom, -32'sd257);
    // literal load: top of range, just below bottom, misaligned
    push_request(OP_LDR, COND_EQ, $urandom, 32'sd1048572, $urandom);
    push_request(OP_LDR, COND_EQ, $urandom, -32'sd1048580, $urandom);
    push_request(OP_LDR, COND_EQ, $urandom, 32'sd2, $urandom);
    // unconditional branch: both range edges, a wild offset, misaligned
    push_request(OP_B, COND_EQ, 32'sd134217724, $urandom, $urandom);
    push_request(OP_B, COND_EQ, -32'sd134217728, $urandom, $urandom);
    push_request(OP_B, COND_EQ, 32'h8000_0000, $urandom, $urandom);
    push_request(OP_B, COND_EQ, 32'sd1, $urandom, $urandom);
    // conditional branch: valid edges, invalid code over a bad offset, out of range
    push_request(OP_BCOND, COND_LE, -32'sd1048576, $urandom, $urandom);
    push_request(OP_BCOND, COND_HI, 32'sd1048572, $urandom, $urandom);
    push_request(OP_BCOND, COND_VC, 32'sd3, $urandom, $urandom);
    push_request(OP_BCOND, COND_AL, 32'sd4, $urandom, $urandom);
    push_request(OP_BCOND, COND_LO, 32'sd1048576, $urandom, $urandom);
    push_request(OP_BCOND, COND_MI, 32'sd0, $urandom, $urandom);
    push_request(OP_UNKNOWN, COND_EQ, $urandom, $urandom, $urandom);

    // random: full-width operands, immediates and offsets steered toward their edges
    for (int n = 0; n < NumRandom; n++) begin
      item.opcode = 4'($urandom_range(0, 15));
      item.cond   = 4'($urandom_range(0, 15));
      item.first  = $urandom;
      item.second = $urandom;
      item.third  = $urandom;
      case (op_e'(item.opcode))
        OP_LDUR, OP_STUR: begin
          if ($urandom_range(0, 9) < 8) item.third = int'($urandom_range(0, 560)) - 280;
        end
        OP_LDR: item.second = pick_offset(19);
        OP_B:   item.first  = pick_offset(26);
        OP_BCOND: begin
          item.first = pick_offset(19);
          if ($urandom_range(0, 3) != 0) begin
            sel       = $urandom_range(0, 9);
            item.cond = 4'((sel < 4) ? sel : sel + 4);
          end
        end
        default: ;
      endcase
      pending_requests.insert(pending_requests.size(), item);
    end

    repeat (9) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    // all requests handed over, then all responses back, then a short drain
    while (pending_requests.size() != 0 || req_valid) @(negedge clk_i);
    while (expected_encodings.size() != 0) @(negedge clk_i);
    repeat (16) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("tb_arm64_subset_instruction_encoder OK");
    end else begin
      $display("tb_arm64_subset_instruction_encoder NOT OK");
    end
    $finish;
  end

  // watchdog well past the slowest legal run
  initial begin
    #5_000_000;
    $display("tb_arm64_subset_instruction_encoder NOT OK");
    $finish;
  end

endmodule
